>>> sv/lpr_pkg.sv
// Shared types and constants for the longest prefix route lookup.
// Holds the action codes, field widths and the item record that walks the cell chain.
// No dependencies.
`timescale 1ns / 1ps

package lpr_pkg;

    localparam int ADDR_W  = 32;
    localparam int SLOT_W  = 4;
    localparam int IFACE_W = 6;
    localparam int DEV_W   = 4;
    localparam int PLEN_W  = 6;
    localparam int ACT_W   = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_WRITE  = 2'd0,
        ACT_INVAL  = 2'd1,
        ACT_LOOKUP = 2'd2
    } lpr_action_t;

    typedef struct packed {
        lpr_action_t          action;
        logic [SLOT_W-1:0]    slot;
        logic [ADDR_W-1:0]    network;
        logic [ADDR_W-1:0]    mask;
        logic [PLEN_W-1:0]    mask_ones;
        logic                 gw_flag;
        logic [IFACE_W-1:0]   iface;
        logic [DEV_W-1:0]     device;
        logic [ADDR_W-1:0]    addr;
        logic                 filter;
        logic [DEV_W-1:0]     target;
        logic                 found;
        logic [IFACE_W-1:0]   best_iface;
        logic                 best_gw;
        logic [PLEN_W-1:0]    best_plen;
    } lpr_token_t;

    function automatic logic [PLEN_W-1:0] lpr_ones(input logic [ADDR_W-1:0] v);
        return PLEN_W'($countones(v));
    endfunction

endpackage

>>> sv/lpr_ifs.sv
// Request and response channel interfaces for the route lookup.
// Each carries valid, ready and the item fields; depends on lpr_pkg.
`timescale 1ns / 1ps

interface lpr_req_if
    import lpr_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [ACT_W-1:0]     action;
    logic [SLOT_W-1:0]    slot;
    logic [ADDR_W-1:0]    route_network;
    logic [ADDR_W-1:0]    route_mask;
    logic                 route_is_default;
    logic [IFACE_W-1:0]   route_iface;
    logic [DEV_W-1:0]     route_device;
    logic [ADDR_W-1:0]    lookup_address;
    logic                 filter_by_device;
    logic [DEV_W-1:0]     target_device;

    modport source (
        output valid, action, slot, route_network, route_mask, route_is_default,
               route_iface, route_device, lookup_address, filter_by_device,
               target_device,
        input  ready
    );
    modport sink (
        input  valid, action, slot, route_network, route_mask, route_is_default,
               route_iface, route_device, lookup_address, filter_by_device,
               target_device,
        output ready
    );
endinterface

interface lpr_rsp_if
    import lpr_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 found;
    logic [IFACE_W-1:0]   match_iface;
    logic                 match_is_default;
    logic [PLEN_W-1:0]    prefix_length;

    modport source (
        output valid, found, match_iface, match_is_default, prefix_length,
        input  ready
    );
    modport sink (
        input  valid, found, match_iface, match_is_default, prefix_length,
        output ready
    );
endinterface

>>> sv/lpr_cell.sv
// One route slot of the lookup chain: holds the slot entry and one item stage.
// Applies writes and invalidates to its slot, updates the best match of lookups.
// Depends on lpr_pkg.
`timescale 1ns / 1ps

module lpr_cell
    import lpr_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic       tok_valid_in,
    input  lpr_token_t tok_in,
    output logic       tok_valid_out,
    output lpr_token_t tok_out
);

    logic                 entry_valid_reg;
    logic                 entry_valid_next;
    logic [ADDR_W-1:0]    entry_net_reg;
    logic [ADDR_W-1:0]    entry_mask_reg;
    logic [PLEN_W-1:0]    entry_ones_reg;
    logic                 entry_def_reg;
    logic [IFACE_W-1:0]   entry_iface_reg;
    logic [DEV_W-1:0]     entry_dev_reg;

    logic                 tok_valid_reg;
    lpr_token_t           tok_reg;
    lpr_token_t           tok_next;

    logic                 slot_sel;
    logic                 write_sel;
    logic                 inval_sel;
    logic                 is_lookup;
    logic                 hit;

    always_comb
    begin
        slot_sel  = tok_valid_in && (int'(tok_in.slot) == IDX);
        write_sel = 1'b0;
        inval_sel = 1'b0;
        is_lookup = 1'b0;
        case (tok_in.action)
            ACT_WRITE:  write_sel = slot_sel;
            ACT_INVAL:  inval_sel = slot_sel;
            ACT_LOOKUP: is_lookup = 1'b1;
            default:    ;
        endcase

        hit = is_lookup && entry_valid_reg
            && ((tok_in.addr & entry_mask_reg) == entry_net_reg)
            && (!tok_in.filter || (entry_dev_reg == tok_in.target))
            && (entry_ones_reg >= tok_in.best_plen);

        tok_next = tok_in;
        if (hit)
        begin
            tok_next.found      = 1'b1;
            tok_next.best_iface = entry_iface_reg;
            tok_next.best_gw    = entry_def_reg;
            tok_next.best_plen  = entry_ones_reg;
        end

        entry_valid_next = entry_valid_reg;
        if (write_sel)
        begin
            entry_valid_next = 1'b1;
        end
        else if (inval_sel)
        begin
            entry_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
            tok_valid_reg   <= 1'b0;
        end
        else if (advance)
        begin
            entry_valid_reg <= entry_valid_next;
            tok_valid_reg   <= tok_valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tok_reg <= tok_next;
        end
        if (advance && write_sel)
        begin
            entry_net_reg   <= tok_in.network;
            entry_mask_reg  <= tok_in.mask;
            entry_ones_reg  <= tok_in.mask_ones;
            entry_def_reg   <= tok_in.gw_flag;
            entry_iface_reg <= tok_in.iface;
            entry_dev_reg   <= tok_in.device;
        end
    end

    assign tok_valid_out = tok_valid_reg;
    assign tok_out       = tok_reg;

    a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && write_sel) |=> entry_valid_reg)
        else $error("slot write did not mark the entry valid");

    a_inval_clears_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && inval_sel) |=> !entry_valid_reg)
        else $error("slot invalidate left the entry valid");

    a_ones_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        entry_valid_reg |-> (entry_ones_reg == PLEN_W'($countones(entry_mask_reg))))
        else $error("stored prefix length disagrees with stored mask");

endmodule

>>> sv/longest_prefix_route_lookup.sv
// Each item walks one registered cell per slot, in slot order, from req to rsp.
// Throughput: one item per cycle while no result waits untaken on rsp.
// The whole chain holds while a result waits on rsp and is not taken.
// Reset clears all slot valid bits and chain stage flags at once; no clearing pass.
// Depends on lpr_pkg, lpr_req_if, lpr_rsp_if and lpr_cell.
`timescale 1ns / 1ps

module longest_prefix_route_lookup
    import lpr_pkg::*;
#(
    parameter int ROUTE_SLOTS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    lpr_req_if.sink       req,
    lpr_rsp_if.source     rsp
);

    logic       advance;
    logic       stage_valid [ROUTE_SLOTS+1];
    lpr_token_t stage_tok   [ROUTE_SLOTS+1];

    assign advance   = !stage_valid[ROUTE_SLOTS] || rsp.ready;
    assign req.ready = advance;

    always_comb
    begin
        stage_valid[0]            = req.valid;
        stage_tok[0].action       = lpr_action_t'(req.action);
        stage_tok[0].slot         = req.slot;
        stage_tok[0].network      = req.route_network;
        stage_tok[0].mask         = req.route_mask;
        stage_tok[0].mask_ones    = lpr_ones(req.route_mask);
        stage_tok[0].gw_flag      = req.route_is_default;
        stage_tok[0].iface        = req.route_iface;
        stage_tok[0].device       = req.route_device;
        stage_tok[0].addr         = req.lookup_address;
        stage_tok[0].filter       = req.filter_by_device;
        stage_tok[0].target       = req.target_device;
        stage_tok[0].found        = 1'b0;
        stage_tok[0].best_iface   = '0;
        stage_tok[0].best_gw      = 1'b0;
        stage_tok[0].best_plen    = '0;
    end

    for (genvar g = 0; g < ROUTE_SLOTS; g++)
    begin : g_cell
        lpr_cell #(
            .IDX (g)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .advance       (advance),
            .tok_valid_in  (stage_valid[g]),
            .tok_in        (stage_tok[g]),
            .tok_valid_out (stage_valid[g+1]),
            .tok_out       (stage_tok[g+1])
        );
    end

    assign rsp.valid            = stage_valid[ROUTE_SLOTS];
    assign rsp.found            = stage_tok[ROUTE_SLOTS].found;
    assign rsp.match_iface      = stage_tok[ROUTE_SLOTS].best_iface;
    assign rsp.match_is_default = stage_tok[ROUTE_SLOTS].best_gw;
    assign rsp.prefix_length    = stage_tok[ROUTE_SLOTS].best_plen;

    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.found) |->
            (rsp.match_iface == '0 && !rsp.match_is_default && rsp.prefix_length == '0))
        else $error("miss result carries non-zero fields");

    a_only_lookup_finds: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && stage_tok[ROUTE_SLOTS].action != ACT_LOOKUP) |-> !rsp.found)
        else $error("non-lookup item reported a match");

    a_plen_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.prefix_length <= PLEN_W'(ADDR_W)))
        else $error("prefix length beyond address width");

endmodule

>>> bench/tb_top.sv
// Self-checking bench for longest_prefix_route_lookup: writes, invals, lookups, unused codes.
// Predicts every result with its own route table and checks them in order on rsp.
// Depends on lpr_pkg, lpr_req_if, lpr_rsp_if and the block itself.
`timescale 1ns / 1ps

module tb_top;
    import lpr_pkg::*;

    localparam int ROUTE_SLOTS = 16;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int SETTLE_CYCLES = ROUTE_SLOTS + 8;
    localparam int LONG_HOLD_CYCLES = 120;

    typedef struct {
        logic [ACT_W-1:0]   act;
        logic [SLOT_W-1:0]  slot;
        logic [ADDR_W-1:0]  network;
        logic [ADDR_W-1:0]  mask;
        logic               gw_flag;
        logic [IFACE_W-1:0] iface;
        logic [DEV_W-1:0]   device;
        logic [ADDR_W-1:0]  addr;
        logic               filter;
        logic [DEV_W-1:0]   target;
    } route_item_t;

    typedef struct packed {
        logic               found;
        logic [IFACE_W-1:0] iface;
        logic               gw_flag;
        logic [PLEN_W-1:0]  plen;
    } route_answer_t;

    class route_scoreboard;
        bit                 live [ROUTE_SLOTS];
        logic [ADDR_W-1:0]  net_tab [ROUTE_SLOTS];
        logic [ADDR_W-1:0]  mask_tab [ROUTE_SLOTS];
        logic               dflt_tab [ROUTE_SLOTS];
        logic [IFACE_W-1:0] iface_tab [ROUTE_SLOTS];
        logic [DEV_W-1:0]   dev_tab [ROUTE_SLOTS];
        route_answer_t      answers_due [$];
        int                 mismatches;

        function void note_item(route_item_t it);
            route_answer_t ans;
            int best;
            int ones;
            ans = '0;
            best = 0;
            if (it.act == ACT_WRITE) begin
                live[it.slot]      = 1'b1;
                net_tab[it.slot]   = it.network;
                mask_tab[it.slot]  = it.mask;
                dflt_tab[it.slot]  = it.gw_flag;
                iface_tab[it.slot] = it.iface;
                dev_tab[it.slot]   = it.device;
            end
            else if (it.act == ACT_INVAL) begin
                live[it.slot] = 1'b0;
            end
            else if (it.act == ACT_LOOKUP) begin
                for (int s = 0; s < ROUTE_SLOTS; s++) begin
                    if (live[s] && ((it.addr & mask_tab[s]) == net_tab[s])
                        && (!it.filter || dev_tab[s] == it.target))
                    begin
                        ones = $countones(mask_tab[s]);
                        if (best <= ones)
                        begin
                            best          = ones;
                            ans.found     = 1'b1;
                            ans.iface     = iface_tab[s];
                            ans.gw_flag   = dflt_tab[s];
                            ans.plen      = PLEN_W'(ones);
                        end
                    end
                end
            end
            answers_due.push_back(ans);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= 100)
                $display("route mismatch at %0t: %s", $realtime, what);
        endtask

        task check_answer(route_answer_t got);
            route_answer_t want;
            if (answers_due.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result found=%0d iface=%0d dflt=%0d plen=%0d",
                    got.found, got.iface, got.gw_flag, got.plen));
                return;
            end
            want = answers_due.pop_front();
            if (got.found !== want.found || got.iface !== want.iface
                || got.gw_flag !== want.gw_flag || got.plen !== want.plen)
            begin
                report_mismatch($sformatf(
                    "got found=%0d iface=%0d dflt=%0d plen=%0d, want %0d/%0d/%0d/%0d",
                    got.found, got.iface, got.gw_flag, got.plen,
                    want.found, want.iface, want.gw_flag, want.plen));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;

    lpr_req_if req ();
    lpr_rsp_if rsp ();

    longest_prefix_route_lookup #(
        .ROUTE_SLOTS (ROUTE_SLOTS)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    route_scoreboard board = new;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;

    logic [ADDR_W-1:0] shadow_net  [ROUTE_SLOTS] = '{default: '0};
    logic [ADDR_W-1:0] shadow_mask [ROUTE_SLOTS] = '{default: '0};
    logic [DEV_W-1:0]  shadow_dev  [ROUTE_SLOTS] = '{default: '0};

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("** longest_prefix_route_lookup: FAILED **");
        $finish;
    end

    initial
    begin
        int hold_left;
        hold_left = 0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                rsp.ready <= 1'b0;
                hold_left--;
            end
            else
                rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        route_answer_t got;
        if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
        begin
            got.found   = rsp.found;
            got.iface   = rsp.match_iface;
            got.gw_flag = rsp.match_is_default;
            got.plen    = rsp.prefix_length;
            board.check_answer(got);
        end
    end

    function automatic route_item_t noise_item();
        route_item_t it;
        it.act        = ACT_W'($urandom_range(3));
        it.slot       = SLOT_W'($urandom);
        it.network    = $urandom;
        it.mask       = $urandom;
        it.gw_flag    = 1'($urandom);
        it.iface      = IFACE_W'($urandom);
        it.device     = DEV_W'($urandom);
        it.addr       = $urandom;
        it.filter     = 1'($urandom);
        it.target     = DEV_W'($urandom);
        return it;
    endfunction

    task automatic offer(route_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid            <= 1'b1;
        req.action           <= it.act;
        req.slot             <= it.slot;
        req.route_network    <= it.network;
        req.route_mask       <= it.mask;
        req.route_is_default <= it.gw_flag;
        req.route_iface      <= it.iface;
        req.route_device     <= it.device;
        req.lookup_address   <= it.addr;
        req.filter_by_device <= it.filter;
        req.target_device    <= it.target;
        do @(posedge clk); while (req.ready !== 1'b1);
        board.note_item(it);
    endtask

    task automatic send_write(logic [SLOT_W-1:0] slot, logic [ADDR_W-1:0] net,
                              logic [ADDR_W-1:0] mask, logic dflt,
                              logic [IFACE_W-1:0] iface, logic [DEV_W-1:0] dev);
        route_item_t it;
        it            = noise_item();
        it.act        = ACT_WRITE;
        it.slot       = slot;
        it.network    = net;
        it.mask       = mask;
        it.gw_flag    = dflt;
        it.iface      = iface;
        it.device     = dev;
        shadow_net[slot]  = net;
        shadow_mask[slot] = mask;
        shadow_dev[slot]  = dev;
        offer(it);
    endtask

    task automatic send_inval(logic [SLOT_W-1:0] slot);
        route_item_t it;
        it      = noise_item();
        it.act  = ACT_INVAL;
        it.slot = slot;
        offer(it);
    endtask

    task automatic send_lookup(logic [ADDR_W-1:0] addr, logic filter, logic [DEV_W-1:0] target);
        route_item_t it;
        it        = noise_item();
        it.act    = ACT_LOOKUP;
        it.addr   = addr;
        it.filter = filter;
        it.target = target;
        offer(it);
    endtask

    task automatic send_unused();
        route_item_t it;
        it     = noise_item();
        it.act = ACT_UNUSED;
        offer(it);
    endtask

    task automatic run_random(int count);
        int sent;
        int pick;
        int len;
        int s;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] net;
        logic [ADDR_W-1:0] addr;
        logic [DEV_W-1:0]  dev;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
            begin
                len  = $urandom_range(32);
                mask = (len == 0) ? '0 : (32'hFFFF_FFFF << (32 - len));
                if ($urandom_range(7) == 0)
                    mask = $urandom;
                net = $urandom & mask;
                if ($urandom_range(9) == 0)
                    net = $urandom;
                dev = ($urandom_range(4) == 0) ? DEV_W'($urandom_range(15))
                                               : DEV_W'($urandom_range(3));
                send_write(SLOT_W'($urandom_range(ROUTE_SLOTS - 1)), net, mask,
                           1'($urandom), IFACE_W'($urandom), dev);
                sent++;
            end
            else if (pick < 40)
            begin
                send_inval(SLOT_W'($urandom_range(ROUTE_SLOTS - 1)));
                sent++;
            end
            else if (pick < 45)
                send_unused();
            else
            begin
                s    = $urandom_range(ROUTE_SLOTS - 1);
                addr = $urandom;
                if ($urandom_range(9) < 7)
                    addr = (shadow_net[s] & shadow_mask[s]) | (addr & ~shadow_mask[s]);
                dev = ($urandom_range(9) < 7) ? shadow_dev[s] : DEV_W'($urandom_range(15));
                send_lookup(addr, $urandom_range(9) < 3, dev);
                sent++;
            end
        end
    endtask

    initial
    begin
        int drain_cycles;
        rst_n                <= 1'b0;
        req.valid            <= 1'b0;
        req.action           <= ACT_WRITE;
        req.slot             <= '0;
        req.route_network    <= '0;
        req.route_mask       <= '0;
        req.route_is_default <= 1'b0;
        req.route_iface      <= '0;
        req.route_device     <= '0;
        req.lookup_address   <= '0;
        req.filter_by_device <= 1'b0;
        req.target_device    <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_lookup(32'h0A01_0203, 1'b0, 4'd0);
        send_write(4'd0, 32'h0000_0000, 32'h0000_0000, 1'b1, 6'd1, 4'd0);
        send_lookup(32'hFFFF_FFFF, 1'b0, 4'd0);
        send_write(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 6'd63, 4'd15);
        send_lookup(32'hFFFF_FFFF, 1'b0, 4'd0);
        send_lookup(32'hFFFF_FFFF, 1'b1, 4'd15);
        send_lookup(32'hFFFF_FFFF, 1'b1, 4'd0);
        send_lookup(32'hFFFF_FFFF, 1'b1, 4'd7);
        send_write(4'd3, 32'h0A00_0000, 32'hFF00_0000, 1'b0, 6'd10, 4'd2);
        send_write(4'd9, 32'h0A00_0000, 32'hFF00_0000, 1'b0, 6'd20, 4'd3);
        send_lookup(32'h0A01_0203, 1'b0, 4'd0);
        send_lookup(32'h0A01_0203, 1'b1, 4'd2);
        send_write(4'd5, 32'h0A01_0000, 32'hFFFF_0000, 1'b0, 6'd33, 4'd2);
        send_lookup(32'h0A01_0203, 1'b0, 4'd0);
        send_inval(4'd5);
        send_lookup(32'h0A01_0203, 1'b0, 4'd0);
        send_inval(4'd9);
        send_lookup(32'h0A01_0203, 1'b0, 4'd0);
        send_unused();
        send_write(4'd7, 32'h0102_0304, 32'h0F0F_0F0F, 1'b1, 6'd5, 4'd1);
        send_lookup(32'h1112_1314, 1'b0, 4'd0);
        send_inval(4'd12);
        send_inval(4'd0);
        send_lookup(32'h0B00_0000, 1'b0, 4'd0);
        send_inval(4'd15);

        run_random(ITEMS_PER_PHASE / 2);
        hold_request = LONG_HOLD_CYCLES;
        run_random(ITEMS_PER_PHASE / 2);

        // hold the sender until the pipeline has emptied
        req.valid <= 1'b0;
        do @(posedge clk); while (board.answers_due.size() != 0);

        send_idle_pct = 81;
        run_random(ITEMS_PER_PHASE);
        send_idle_pct  = 0;
        recv_stall_pct = 81;
        run_random(ITEMS_PER_PHASE);
        send_idle_pct  = 22;
        recv_stall_pct = 22;
        run_random(ITEMS_PER_PHASE);

        recv_stall_pct = 0;
        req.valid <= 1'b0;
        drain_cycles = 0;
        do
        begin
            @(posedge clk);
            drain_cycles++;
        end
        while (board.answers_due.size() != 0 && drain_cycles < 50000);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.answers_due.size() != 0)
            board.report_mismatch($sformatf("%0d results never arrived",
                                            board.answers_due.size()));

        if (board.mismatches == 0)
            $display("** longest_prefix_route_lookup: PASSED **");
        else
            $display("** longest_prefix_route_lookup: FAILED **");
        $finish;
    end

endmodule

>>> sim.f
sv/lpr_pkg.sv
sv/lpr_ifs.sv
sv/lpr_cell.sv
sv/longest_prefix_route_lookup.sv
bench/tb_top.sv
